// ===== src/pfr_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package pfr_pkg;

	localparam int DIMS       = 3;
	localparam int FRAC_BITS  = 8;
	localparam int GAIN_SHIFT = 2 * FRAC_BITS;

	localparam int COORD_W = 24;
	localparam int DIFF_W  = COORD_W + 1;
	localparam int SQ_W    = 2 * DIFF_W;
	localparam int SUM_W   = SQ_W + 2;
	localparam int RANGE_W = 23;
	localparam int VAL_W   = 2 * RANGE_W;
	localparam int HALF_W  = VAL_W / 2;
	localparam int ROOT_W  = RANGE_W;
	localparam int GAIN_W  = 19;
	localparam int MAGC_W  = RANGE_W + GAIN_W;
	localparam int NSPLIT  = MAGC_W / 2;
	localparam int NUMP_W  = VAL_W + MAGC_W;
	localparam int NUM_W   = NUMP_W + GAIN_SHIFT;
	localparam int Q_W     = 32;
	localparam int HI_W    = NUM_W - Q_W;
	localparam int DEN_W   = 2 * VAL_W;
	localparam int REM_W   = DEN_W + 1;
	localparam int FORCE_W = 32;

	localparam logic [GAIN_W-1:0]  GAIN      = GAIN_W'(500000);
	localparam logic [FORCE_W-1:0] FORCE_MAX = 32'h7FFF_FFFF;
	localparam logic [FORCE_W-1:0] FORCE_MIN = 32'h8000_0000;

	typedef struct packed {
		logic             in_reach;
		logic             nz;
		logic             neg_x;
		logic             neg_y;
		logic [VAL_W-1:0] s;
		logic [VAL_W-1:0] ax2;
		logic [VAL_W-1:0] ay2;
	} sq_side_t;

	typedef struct packed {
		logic in_reach;
		logic nz;
		logic neg;
	} div_tag_t;

endpackage
`default_nettype wire

// ===== src/pfr_isqrt.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Floor square root, one result bit per stage.
module pfr_isqrt (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         en,
	input  wire logic                         in_valid,
	input  wire logic [pfr_pkg::VAL_W-1:0]    value,
	input  wire pfr_pkg::sq_side_t            in_side,
	output logic                              out_valid,
	output logic [pfr_pkg::ROOT_W-1:0]        root,
	output pfr_pkg::sq_side_t                 out_side
);

	localparam int N = pfr_pkg::ROOT_W;
	localparam int W = pfr_pkg::VAL_W;

	logic              vld_s  [0:N-1];
	logic [W-1:0]      rem_s  [0:N-1];
	logic [N-1:0]      root_s [0:N-1];
	pfr_pkg::sq_side_t side_s [0:N-1];

	for (genvar k = 0; k < N; k++) begin : g_stage
		localparam int B = N - 1 - k;
		logic              pv;
		logic [W-1:0]      prem;
		logic [N-1:0]      proot;
		pfr_pkg::sq_side_t pside;
		logic [W:0]        trial;
		logic              take;

		if (k == 0) begin : g_in
			assign pv    = in_valid;
			assign prem  = value;
			assign proot = '0;
			assign pside = in_side;
		end else begin : g_mid
			assign pv    = vld_s[k-1];
			assign prem  = rem_s[k-1];
			assign proot = root_s[k-1];
			assign pside = side_s[k-1];
		end

		// (root + 2^B)^2 - root^2
		assign trial = ((W+1)'(proot) << (B + 1)) + ((W+1)'(1) << (2 * B));
		assign take  = {1'b0, prem} >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (en) begin
				vld_s[k] <= pv;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k]  <= take ? W'({1'b0, prem} - trial) : prem;
				root_s[k] <= take ? (proot | (N'(1) << B)) : proot;
				side_s[k] <= pside;
			end
		end
	end

	assign out_valid = vld_s[N-1];
	assign root      = root_s[N-1];
	assign out_side  = side_s[N-1];

endmodule
`default_nettype wire

// ===== src/pfr_divider.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Restoring divider: overflow check stage, then one quotient bit per stage.
module pfr_divider (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        en,
	input  wire logic                        in_valid,
	input  wire logic [pfr_pkg::HI_W-1:0]    num_hi,
	input  wire logic [pfr_pkg::Q_W-1:0]     num_lo,
	input  wire logic [pfr_pkg::DEN_W-1:0]   den,
	input  wire pfr_pkg::div_tag_t           in_tag,
	output logic                             out_valid,
	output logic [pfr_pkg::Q_W-1:0]          quot,
	output logic                             ovf,
	output pfr_pkg::div_tag_t                out_tag
);

	localparam int QW = pfr_pkg::Q_W;
	localparam int DW = pfr_pkg::DEN_W;
	localparam int RW = pfr_pkg::REM_W;

	logic              vld_s  [0:QW];
	logic [DW-1:0]     rem_s  [0:QW];
	logic [DW-1:0]     den_s  [0:QW];
	logic [QW-1:0]     bits_s [0:QW];
	logic [QW-1:0]     q_s    [0:QW];
	logic              ovf_s  [0:QW];
	pfr_pkg::div_tag_t tag_s  [0:QW];

	logic over;
	// quotient reaches 2^Q_W when the upper numerator is not below the divisor
	assign over = DW'(num_hi) >= den;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else if (en) begin
			vld_s[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0]  <= over ? '0 : DW'(num_hi);
			den_s[0]  <= den;
			bits_s[0] <= num_lo;
			q_s[0]    <= '0;
			ovf_s[0]  <= over;
			tag_s[0]  <= in_tag;
		end
	end

	for (genvar k = 1; k <= QW; k++) begin : g_stage
		logic [RW-1:0] sh;
		logic [RW-1:0] diff;
		logic          take;

		assign sh   = {rem_s[k-1], bits_s[k-1][QW-1]};
		assign diff = sh - {1'b0, den_s[k-1]};
		assign take = sh >= {1'b0, den_s[k-1]};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (en) begin
				vld_s[k] <= vld_s[k-1];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k]  <= take ? DW'(diff) : DW'(sh);
				den_s[k]  <= den_s[k-1];
				bits_s[k] <= {bits_s[k-1][QW-2:0], 1'b0};
				q_s[k]    <= {q_s[k-1][QW-2:0], take};
				ovf_s[k]  <= ovf_s[k-1];
				tag_s[k]  <= tag_s[k-1];
			end
		end
	end

	assign out_valid = vld_s[QW];
	assign quot      = q_s[QW];
	assign ovf       = ovf_s[QW];
	assign out_tag   = tag_s[QW];

	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s[QW] && !ovf_s[QW] && tag_s[QW].in_reach && tag_s[QW].nz
			|-> rem_s[QW] < den_s[QW])
		else $error("divider remainder not below divisor");

endmodule
`default_nettype wire

// ===== src/potential_field_repulsion.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Repulsive force of an artificial potential field for one agent/obstacle pair per
// transfer. Input: six signed Q15.8 coordinates; output: force_x/force_y in signed
// Q23.8, within_range and saturated. Force per axis is
// sgn(dx)*dx^2*500000*4^FRAC_BITS*(R-d)/(S*d*R), S the squared distance, d its floor
// square root, truncated toward zero and clipped to 32 bits. Fully pipelined: one
// pair accepted every cycle unless the output stalls (7 front stages of difference,
// square, sum, products and partial-product sums; 23 square-root stages; 33
// divider stages; 1 output register). influence_range may be written only while
// the pipeline is empty. A stall at the output holds the whole pipeline.
module potential_field_repulsion (
	input  wire logic         clk,
	input  wire logic         arst_n,
	// tdata: self_x, self_y, self_z, obstacle_x, obstacle_y, obstacle_z (24 b each)
	input  wire logic [143:0] s_tdata,
	input  wire logic         s_tvalid,
	output logic              s_tready,
	// tdata: force_x [31:0], force_y [63:32]
	output logic [63:0]       m_tdata,
	// tuser: within_range [0], saturated [1]
	output logic [1:0]        m_tuser,
	output logic              m_tvalid,
	input  wire logic         m_tready,
	// influence_range write
	input  wire logic [22:0]  cfg_data,
	input  wire logic         cfg_valid,
	output logic              cfg_ready
);

	localparam int CW = pfr_pkg::COORD_W;
	localparam int DF = pfr_pkg::DIFF_W;
	localparam int VW = pfr_pkg::VAL_W;
	localparam int HW = pfr_pkg::HALF_W;
	localparam int NS = pfr_pkg::NSPLIT;
	localparam int MW = pfr_pkg::MAGC_W;
	localparam int FW = pfr_pkg::FORCE_W;

	typedef struct packed {
		logic [VW-1:0] p00;
		logic [VW-1:0] p01;
		logic [VW-1:0] p10;
		logic [VW-1:0] p11;
	} pp_t;

	typedef struct packed {
		logic [VW-1:0] lo;
		logic [VW-1:0] hi;
		logic [VW:0]   mid;
	} ps_t;

	function automatic pp_t den_pp(input logic [VW-1:0] a, input logic [VW-1:0] b);
		pp_t r;
		r.p00 = VW'(a[HW-1:0])  * VW'(b[HW-1:0]);
		r.p01 = VW'(a[HW-1:0])  * VW'(b[VW-1:HW]);
		r.p10 = VW'(a[VW-1:HW]) * VW'(b[HW-1:0]);
		r.p11 = VW'(a[VW-1:HW]) * VW'(b[VW-1:HW]);
		return r;
	endfunction

	function automatic pp_t num_pp(input logic [VW-1:0] a, input logic [MW-1:0] m);
		pp_t r;
		r.p00 = VW'(a[NS-1:0])  * VW'(m[NS-1:0]);
		r.p01 = VW'(a[NS-1:0])  * VW'(m[MW-1:NS]);
		r.p10 = VW'(a[VW-1:NS]) * VW'(m[NS-1:0]);
		r.p11 = VW'(a[VW-1:NS]) * VW'(m[MW-1:NS]);
		return r;
	endfunction

	function automatic ps_t pp_sum(input pp_t p);
		ps_t r;
		r.lo  = p.p00;
		r.hi  = p.p11;
		r.mid = (VW+1)'(p.p01) + (VW+1)'(p.p10);
		return r;
	endfunction

	// {saturated, force} from quotient, overflow and sign
	function automatic logic [FW:0] finish(input logic [FW-1:0] q, input logic of,
			input logic neg);
		logic [FW:0] r;
		if (neg) begin
			if (of || q > pfr_pkg::FORCE_MIN) begin
				r = {1'b1, pfr_pkg::FORCE_MIN};
			end else begin
				r = {1'b0, FW'(-q)};
			end
		end else begin
			if (of || q > pfr_pkg::FORCE_MAX) begin
				r = {1'b1, pfr_pkg::FORCE_MAX};
			end else begin
				r = {1'b0, q};
			end
		end
		return r;
	endfunction

	// global advance: whole pipeline moves unless the output is held
	logic en;
	logic o_valid_q;
	assign en       = !o_valid_q || m_tready;
	assign s_tready = en;

	// config
	logic [pfr_pkg::RANGE_W-1:0] range_q;
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			range_q <= '0;
		end else if (cfg_valid) begin
			range_q <= cfg_data;
		end
	end

	// s1: differences (agent minus obstacle)
	logic signed [DF-1:0] dx_c, dy_c, dz_c;
	assign dx_c = $signed({s_tdata[CW-1], s_tdata[CW-1:0]})
		- $signed({s_tdata[4*CW-1], s_tdata[4*CW-1:3*CW]});
	assign dy_c = $signed({s_tdata[2*CW-1], s_tdata[2*CW-1:CW]})
		- $signed({s_tdata[5*CW-1], s_tdata[5*CW-1:4*CW]});
	assign dz_c = (pfr_pkg::DIMS >= 3)
		? $signed({s_tdata[3*CW-1], s_tdata[3*CW-1:2*CW]})
			- $signed({s_tdata[6*CW-1], s_tdata[6*CW-1:5*CW]})
		: '0;

	logic                 v_s1;
	logic signed [DF-1:0] dx_s1, dy_s1, dz_s1;

	// s2: squares of magnitudes, R^2
	logic [DF-1:0] mx, my, mz;
	assign mx = dx_s1[DF-1] ? DF'(-dx_s1) : DF'(dx_s1);
	assign my = dy_s1[DF-1] ? DF'(-dy_s1) : DF'(dy_s1);
	assign mz = dz_s1[DF-1] ? DF'(-dz_s1) : DF'(dz_s1);

	logic                        v_s2;
	logic [pfr_pkg::SQ_W-1:0]    ax2_s2, ay2_s2, az2_s2;
	logic [VW-1:0]               rr_s2;
	logic                        nx_s2, ny_s2;

	// s3: squared distance, range test
	logic [pfr_pkg::SUM_W-1:0] sum_c;
	assign sum_c = pfr_pkg::SUM_W'(ax2_s2) + pfr_pkg::SUM_W'(ay2_s2)
		+ pfr_pkg::SUM_W'(az2_s2);

	logic              v_s3;
	pfr_pkg::sq_side_t side_s3;

	// square root
	logic                        v_r;
	logic [pfr_pkg::ROOT_W-1:0]  d_r;
	pfr_pkg::sq_side_t           side_r;

	pfr_isqrt u_isqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_s3),
		.value     (side_s3.s),
		.in_side   (side_s3),
		.out_valid (v_r),
		.root      (d_r),
		.out_side  (side_r)
	);

	// s4: d*R and (R-d)*gain
	logic              v_s4;
	logic [VW-1:0]     p_s4;
	logic [MW-1:0]     mc_s4;
	pfr_pkg::sq_side_t side_s4;

	// s5: partial products
	logic              v_s5;
	pp_t               dpp_s5, xpp_s5, ypp_s5;
	pfr_pkg::sq_side_t side_s5;

	// s6: middle sums
	logic              v_s6;
	ps_t               dps_s6, xps_s6, yps_s6;
	pfr_pkg::sq_side_t side_s6;

	// s7: full numerators and denominator
	logic                        v_s7;
	logic [pfr_pkg::NUMP_W-1:0]  nx_s7, ny_s7;
	logic [pfr_pkg::DEN_W-1:0]   den_s7;
	pfr_pkg::div_tag_t           tx_s7, ty_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else if (en) begin
			v_s1 <= s_tvalid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_r;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dx_s1 <= dx_c;
			dy_s1 <= dy_c;
			dz_s1 <= dz_c;

			ax2_s2 <= pfr_pkg::SQ_W'(mx) * pfr_pkg::SQ_W'(mx);
			ay2_s2 <= pfr_pkg::SQ_W'(my) * pfr_pkg::SQ_W'(my);
			az2_s2 <= pfr_pkg::SQ_W'(mz) * pfr_pkg::SQ_W'(mz);
			rr_s2  <= VW'(range_q) * VW'(range_q);
			nx_s2  <= dx_s1[DF-1];
			ny_s2  <= dy_s1[DF-1];

			side_s3.in_reach <= sum_c <= pfr_pkg::SUM_W'(rr_s2);
			side_s3.nz       <= sum_c != '0;
			side_s3.neg_x    <= nx_s2;
			side_s3.neg_y    <= ny_s2;
			side_s3.s        <= sum_c[VW-1:0];
			side_s3.ax2      <= ax2_s2[VW-1:0];
			side_s3.ay2      <= ay2_s2[VW-1:0];

			p_s4    <= VW'(d_r) * VW'(range_q);
			mc_s4   <= MW'(range_q - d_r) * MW'(pfr_pkg::GAIN);
			side_s4 <= side_r;

			dpp_s5  <= den_pp(side_s4.s, p_s4);
			xpp_s5  <= num_pp(side_s4.ax2, mc_s4);
			ypp_s5  <= num_pp(side_s4.ay2, mc_s4);
			side_s5 <= side_s4;

			dps_s6  <= pp_sum(dpp_s5);
			xps_s6  <= pp_sum(xpp_s5);
			yps_s6  <= pp_sum(ypp_s5);
			side_s6 <= side_s5;

			den_s7 <= ((pfr_pkg::DEN_W'(dps_s6.hi) << (2 * HW)) | pfr_pkg::DEN_W'(dps_s6.lo))
				+ (pfr_pkg::DEN_W'(dps_s6.mid) << HW);
			nx_s7  <= ((pfr_pkg::NUMP_W'(xps_s6.hi) << (2 * NS)) | pfr_pkg::NUMP_W'(xps_s6.lo))
				+ (pfr_pkg::NUMP_W'(xps_s6.mid) << NS);
			ny_s7  <= ((pfr_pkg::NUMP_W'(yps_s6.hi) << (2 * NS)) | pfr_pkg::NUMP_W'(yps_s6.lo))
				+ (pfr_pkg::NUMP_W'(yps_s6.mid) << NS);
			tx_s7  <= '{in_reach: side_s6.in_reach, nz: side_s6.nz, neg: side_s6.neg_x};
			ty_s7  <= '{in_reach: side_s6.in_reach, nz: side_s6.nz, neg: side_s6.neg_y};
		end
	end

	// numerator scaled by 4^FRAC_BITS, split into upper part and low quotient bits
	logic [pfr_pkg::NUM_W-1:0] numx, numy;
	assign numx = pfr_pkg::NUM_W'(nx_s7) << pfr_pkg::GAIN_SHIFT;
	assign numy = pfr_pkg::NUM_W'(ny_s7) << pfr_pkg::GAIN_SHIFT;

	logic                      vx, vy, ovx, ovy;
	logic [pfr_pkg::Q_W-1:0]   qx, qy;
	pfr_pkg::div_tag_t         tx, ty;

	pfr_divider u_div_x (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_s7),
		.num_hi    (numx[pfr_pkg::NUM_W-1:pfr_pkg::Q_W]),
		.num_lo    (numx[pfr_pkg::Q_W-1:0]),
		.den       (den_s7),
		.in_tag    (tx_s7),
		.out_valid (vx),
		.quot      (qx),
		.ovf       (ovx),
		.out_tag   (tx)
	);

	pfr_divider u_div_y (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_s7),
		.num_hi    (numy[pfr_pkg::NUM_W-1:pfr_pkg::Q_W]),
		.num_lo    (numy[pfr_pkg::Q_W-1:0]),
		.den       (den_s7),
		.in_tag    (ty_s7),
		.out_valid (vy),
		.quot      (qy),
		.ovf       (ovy),
		.out_tag   (ty)
	);

	// output register
	logic [FW:0]    fx_c, fy_c;
	logic           within_c, act_c;
	assign fx_c     = finish(qx, ovx, tx.neg);
	assign fy_c     = finish(qy, ovy, ty.neg);
	assign within_c = tx.in_reach & ty.in_reach;
	assign act_c    = within_c & tx.nz & ty.nz;

	logic [FW-1:0] force_x_q, force_y_q;
	logic          within_q, sat_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			o_valid_q <= 1'b0;
		end else if (en) begin
			o_valid_q <= vx & vy;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			force_x_q <= act_c ? fx_c[FW-1:0] : '0;
			force_y_q <= act_c ? fy_c[FW-1:0] : '0;
			within_q  <= within_c;
			sat_q     <= act_c & (fx_c[FW] | fy_c[FW]);
		end
	end

	assign m_tvalid = o_valid_q;
	assign m_tdata  = {force_y_q, force_x_q};
	assign m_tuser  = {sat_q, within_q};

	a_out_of_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser[0] |-> m_tdata == '0 && !m_tuser[1])
		else $error("force outside influence range");

	a_sat_limit: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[1] |-> m_tdata[31:0] == pfr_pkg::FORCE_MAX
			|| m_tdata[31:0] == pfr_pkg::FORCE_MIN || m_tdata[63:32] == pfr_pkg::FORCE_MAX
			|| m_tdata[63:32] == pfr_pkg::FORCE_MIN)
		else $error("saturated without a clipped component");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> m_tvalid && !m_tready)
		else $error("input stalled without output backpressure");

endmodule
`default_nettype wire

// ===== tb/sv/potential_field_repulsion_tb.sv =====
`timescale 1ns / 1ps
`default_nettype none
module potential_field_repulsion_tb;

	typedef struct packed {
		logic [31:0] force_x;
		logic [31:0] force_y;
		logic        within_range;
		logic        saturated;
	} force_rec_t;

	// long receiver hold-off; quiet limit sits well above it
	localparam int HOLD_CYCLES  = 400;
	localparam int HOLD_AT      = 600;	// accepted pairs before the hold-off
	localparam int QUIET_LIMIT  = 3000;
	localparam int DRAIN_CYCLES = 80;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic [143:0] s_tdata = '0;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	logic [63:0]  m_tdata;
	logic [1:0]   m_tuser;
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	logic [22:0]  cfg_data = '0;
	logic         cfg_valid = 1'b0;
	logic         cfg_ready;

	logic [143:0] pair_queue[$];
	force_rec_t   force_queue[$];
	logic [22:0]  range_now = '0;
	int           errs = 0;

	potential_field_repulsion uut (
		.clk(clk), .arst_n(arst_n),
		.s_tdata(s_tdata), .s_tvalid(s_tvalid), .s_tready(s_tready),
		.m_tdata(m_tdata), .m_tuser(m_tuser), .m_tvalid(m_tvalid), .m_tready(m_tready),
		.cfg_data(cfg_data), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready)
	);

	always #6 clk = ~clk;

	function automatic logic [63:0] root_floor(logic [63:0] v);
		logic [63:0] res, bit_w;
		res = 0;
		bit_w = 64'd1 << 62;
		while (bit_w > v) bit_w = bit_w >> 2;
		while (bit_w != 0) begin
			if (v >= res + bit_w) begin
				v = v - (res + bit_w);
				res = (res >> 1) + bit_w;
			end else begin
				res = res >> 1;
			end
			bit_w = bit_w >> 2;
		end
		return res;
	endfunction

	// one axis: sgn(diff)*diff^2*gain*4^F*(R-d)/(S*d*R), truncated, clipped
	function automatic logic [31:0] axis_force(logic signed [24:0] diff, logic [63:0] s,
			logic [63:0] d, logic [22:0] r, inout logic sat);
		logic [127:0] mag, num, den, q;
		if (diff == 0) return 32'd0;
		mag = (diff < 0) ? 128'(-diff) : 128'(diff);
		num = mag * mag * 128'd500000 * (128'd1 << (2 * pfr_pkg::FRAC_BITS))
			* 128'(64'(r) - d);
		den = 128'(d) * 128'(r) * 128'(s);
		q = num / den;
		if (diff > 0) begin
			if (q > 128'h7FFF_FFFF) begin
				sat = 1'b1;
				return pfr_pkg::FORCE_MAX;
			end
			return q[31:0];
		end
		if (q > 128'h8000_0000) begin
			sat = 1'b1;
			return pfr_pkg::FORCE_MIN;
		end
		return 32'(0 - q[31:0]);
	endfunction

	function automatic force_rec_t repulsion(logic [143:0] p, logic [22:0] r);
		logic signed [24:0] dif[3];
		logic [63:0]        s, d, a;
		logic               sat;
		force_rec_t         o;
		s = 0;
		for (int k = 0; k < 3; k++) begin
			dif[k] = 25'($signed(p[24*k +: 24])) - 25'($signed(p[24*(k+3) +: 24]));
			if (k >= pfr_pkg::DIMS) dif[k] = 0;
			a = (dif[k] < 0) ? 64'(-dif[k]) : 64'(dif[k]);
			s = s + a * a;
		end
		o = '0;
		sat = 1'b0;
		if (s > 64'(r) * 64'(r)) return o;
		o.within_range = 1'b1;
		if (s == 0) return o;
		d = root_floor(s);
		o.force_x = axis_force(dif[0], s, d, r, sat);
		o.force_y = axis_force(dif[1], s, d, r, sat);
		o.saturated = sat;
		return o;
	endfunction

	function automatic logic [143:0] pack_pair(logic [23:0] sx, sy, sz, ox, oy, oz);
		return {oz, oy, ox, sz, sy, sx};
	endfunction

	// obstacle random, agent at an offset scaled to the range so most pairs land inside
	function automatic logic [143:0] rand_pair(logic [22:0] r);
		logic [23:0] o[3], sv[3];
		int          span;
		o[0] = 24'($urandom); o[1] = 24'($urandom); o[2] = 24'($urandom);
		if ($urandom_range(0, 9) == 0)
			return pack_pair(24'($urandom), 24'($urandom), 24'($urandom),
				o[0], o[1], o[2]);
		span = (r < 4 ? 4 : int'(r)) >> $urandom_range(0, 12);
		if (span < 1) span = 1;
		for (int k = 0; k < 3; k++) begin
			sv[k] = o[k] + 24'($urandom_range(0, 2 * span) - span);
			if ($urandom_range(0, 15) == 0) sv[k] = o[k];	// zero component
		end
		return pack_pair(sv[0], sv[1], sv[2], o[0], o[1], o[2]);
	endfunction

	function automatic void add_pair(logic [143:0] p);
		pair_queue.insert(pair_queue.size(), p);
	endfunction

	// accepted-pair flag, written at the rising edge, read by the driver at the falling one
	logic took = 1'b0;
	int   n_took = 0;

	always @(posedge clk) begin
		took = 1'b0;
		if (s_tvalid && s_tready) begin
			took = 1'b1;
			n_took++;
			force_queue.insert(force_queue.size(), repulsion(s_tdata, range_now));
		end
		if (m_tvalid && m_tready) begin
			if (force_queue.size() == 0) begin
				errs++;
				$error("result transfer with nothing expected");
			end else begin
				force_rec_t e;
				e = force_queue.pop_front();
				if (m_tdata[31:0] !== e.force_x) begin
					errs++;
					$error("force_x exp %h got %h", e.force_x, m_tdata[31:0]);
				end
				if (m_tdata[63:32] !== e.force_y) begin
					errs++;
					$error("force_y exp %h got %h", e.force_y, m_tdata[63:32]);
				end
				if (m_tuser[0] !== e.within_range) begin
					errs++;
					$error("within_range exp %b got %b", e.within_range, m_tuser[0]);
				end
				if (m_tuser[1] !== e.saturated) begin
					errs++;
					$error("saturated exp %b got %b", e.saturated, m_tuser[1]);
				end
			end
		end
	end

	// sender: bursts with gaps, sometimes back to back
	int burst_left = 0, gap_left = 0;
	always @(negedge clk) begin
		if (!s_tvalid || took) begin
			if (gap_left > 0) begin
				gap_left <= gap_left - 1;
				s_tvalid <= 1'b0;
			end else if (pair_queue.size() != 0) begin
				s_tdata <= pair_queue.pop_front();
				s_tvalid <= 1'b1;
				if (burst_left <= 1) begin
					burst_left <= $urandom_range(1, 24);
					gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
				end else begin
					burst_left <= burst_left - 1;
				end
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// receiver: one long hold-off mid-phase, then a stall pattern that changes mode
	int   cyc = 0, hold_left = 0, mode_left = 0, rdy_mode = 0;
	logic hold_done = 1'b0;
	always @(negedge clk) begin
		cyc <= cyc + 1;
		if (!hold_done && n_took >= HOLD_AT) begin
			hold_done <= 1'b1;
			hold_left <= HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			m_tready <= 1'b0;
		end else begin
			if (mode_left == 0) begin
				mode_left <= $urandom_range(50, 300);
				rdy_mode <= $urandom_range(0, 2);
			end else begin
				mode_left <= mode_left - 1;
			end
			case (rdy_mode)
				0: m_tready <= 1'b1;
				1: m_tready <= ($urandom_range(0, 3) != 0);
				default: m_tready <= (cyc % 7 < 3);
			endcase
		end
	end

	// watchdog on transfer-free cycles
	int quiet = 0;
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
			quiet <= 0;
		else
			quiet <= quiet + 1;
		if (quiet >= QUIET_LIMIT) begin
			$display("end of test: mismatches");
			$finish;
		end
	end

	task automatic write_range(logic [22:0] val);
		@(negedge clk);
		cfg_data <= val;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		range_now = val;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic drain;
		wait (pair_queue.size() == 0 && force_queue.size() == 0 && !s_tvalid);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	logic [22:0] ranges[8];
	initial begin
		ranges = '{23'd0, 23'h7FFFFF, 23'd1, 23'd256, 23'd40000, 23'd5000000, 23'd3, 23'd0};
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		// directed pairs at full range: extremes, zero distance, zero components
		write_range(23'h7FFFFF);
		add_pair(pack_pair(24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF,
			24'h800000, 24'h800000, 24'h800000));
		add_pair(pack_pair(24'h800000, 24'h800000, 24'h800000,
			24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF));
		add_pair(pack_pair(24'h123456, 24'h654321, 24'h0F0F0F,
			24'h123456, 24'h654321, 24'h0F0F0F));
		add_pair(pack_pair(24'd1, 24'd0, 24'd0, 24'd0, 24'd0, 24'd0));
		add_pair(pack_pair(24'hFFFFFF, 24'd0, 24'd0, 24'd0, 24'd0, 24'd0));
		add_pair(pack_pair(24'd0, 24'd1, 24'd0, 24'd0, 24'd0, 24'd0));
		add_pair(pack_pair(24'd0, 24'hFFFFFF, 24'd0, 24'd0, 24'd0, 24'd0));
		add_pair(pack_pair(24'd0, 24'd0, 24'd5, 24'd0, 24'd0, 24'd0));
		add_pair(pack_pair(24'd3, 24'hFFFFFD, 24'd0, 24'd0, 24'd0, 24'd0));
		add_pair(pack_pair(24'd1000, 24'd0, 24'd0, 24'd0, 24'd0, 24'd0));
		add_pair(pack_pair(24'h400000, 24'hC00000, 24'd0, 24'd0, 24'd0, 24'd0));
		add_pair(pack_pair(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF,
			24'h000000, 24'h000000, 24'h000000));
		add_pair(pack_pair(24'h7FFFFF, 24'h000000, 24'h000000,
			24'h000000, 24'h000000, 24'h000000));
		add_pair(pack_pair(24'h000000, 24'h800000, 24'h000000,
			24'h000000, 24'h000000, 24'h000000));
		drain();
		write_range(23'd100);
		add_pair(pack_pair(24'd100, 24'd0, 24'd0, 24'd0, 24'd0, 24'd0));
		add_pair(pack_pair(24'd101, 24'd0, 24'd0, 24'd0, 24'd0, 24'd0));
		add_pair(pack_pair(24'd60, 24'd80, 24'd0, 24'd0, 24'd0, 24'd0));
		add_pair(pack_pair(24'd0, 24'd0, 24'd0, 24'd0, 24'd0, 24'd0));
		drain();
		// random phases across the range settings
		foreach (ranges[i]) begin
			logic [22:0] r;
			r = (i == 7) ? 23'($urandom) : ranges[i];
			write_range(r);
			for (int n = 0; n < 165; n++) add_pair(rand_pair(r));
			drain();
		end
		if (errs == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end
endmodule
`default_nettype wire

// ===== filelist.f =====
src/pfr_pkg.sv
src/pfr_isqrt.sv
src/pfr_divider.sv
src/potential_field_repulsion.sv
tb/sv/potential_field_repulsion_tb.sv
